// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// antecedent holds -> consequent holds in the same cycle
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: ante -> cons");

// antecedent holds -> consequent sequence starts in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> cons) \
      else $error("assertion failed: ante => cons");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- rtl/swuj_pkg.sv -----
// ----------------------------------------------------------------------------
// swuj_pkg
// Types and constants of the stack with undo journal
// ----------------------------------------------------------------------------
package swuj_pkg;

   localparam int STACK_DEPTH_DEF   = 64;
   localparam int JOURNAL_DEPTH_DEF = 128;

   localparam int VALUE_W  = 32;
   localparam int DEPTH_W  = 7;
   localparam int OP_W     = 2;
   localparam int STATUS_W = 2;

   localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
   localparam logic [OP_W-1:0] OP_POP   = 2'd1;
   localparam logic [OP_W-1:0] OP_UNDO  = 2'd2;
   // unused code, changes nothing
   localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NOUNDO = 2'd3;

   localparam logic KIND_PUSH = 1'b1;
   localparam logic KIND_POP  = 1'b0;

   typedef struct packed {
      logic [OP_W-1:0]           op;
      logic signed [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] top_value;
      logic [DEPTH_W-1:0]        depth;
      logic [STATUS_W-1:0]       status;
   } rsp_type;

   // journal record: kind bit over the value
   typedef struct packed {
      logic                      kind;
      logic signed [VALUE_W-1:0] value;
   } record_type;

   localparam int RECORD_W = $bits(record_type);

endpackage

// ----- rtl/swuj_ram.sv -----
// ----------------------------------------------------------------------------
// swuj_ram
// Generic simple dual-port RAM, one write and one registered read port
// ----------------------------------------------------------------------------
module swuj_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/stack_with_undo_journal.sv -----
// ----------------------------------------------------------------------------
// stack_with_undo_journal
// Signed data stack with a journal of past pushes and pops for undo
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Each request gives
// exactly one result, shown on rsp_data for one cycle with rsp_strobe high,
// after the states S_EXEC and S_TOP; the result cannot be held off. busy
// drops in the cycle the result shows, so a request is taken only once the
// last one has completed: the accepting idle cycle reads the top of both
// RAMs, S_EXEC writes back and re-reads the new data top, S_TOP forms the
// result. Both stores live in RAM with no clearing pass after reset; only
// entries below the pointers are used, so it is ready right after reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stack_with_undo_journal #(
   parameter int STACK_DEPTH   = swuj_pkg::STACK_DEPTH_DEF,
   parameter int JOURNAL_DEPTH = swuj_pkg::JOURNAL_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  swuj_pkg::req_type req_data,
   output logic              rsp_strobe,
   output swuj_pkg::rsp_type rsp_data
);

   localparam int DAW = $clog2(STACK_DEPTH);
   localparam int JAW = $clog2(JOURNAL_DEPTH);
   localparam int DPW = $clog2(STACK_DEPTH + 1);
   localparam int JPW = $clog2(JOURNAL_DEPTH + 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_TOP
   } state_type;

   state_type                          state_ff, state_in;
   logic [DPW-1:0]                     dptr_ff, dptr_in;
   logic [JPW-1:0]                     jptr_ff, jptr_in;
   swuj_pkg::req_type                  req_ff, req_in;
   logic [swuj_pkg::STATUS_W-1:0]      status_ff, status_in;
   logic                               fwd_ff, fwd_in;
   logic signed [swuj_pkg::VALUE_W-1:0] fwd_val_ff, fwd_val_in;
   logic                               rsp_strobe_ff, rsp_strobe_in;
   swuj_pkg::rsp_type                  rsp_data_ff, rsp_data_in;

   logic                               accept;
   logic                               d_we, j_we;
   logic signed [swuj_pkg::VALUE_W-1:0] d_wdata, d_rdata;
   swuj_pkg::record_type               j_wdata, j_rdata;
   logic [DPW-1:0]                     d_rd_ptr;
   logic [JPW-1:0]                     j_rd_ptr;
   logic                               d_empty, d_full, j_empty, j_full;

   assign accept  = start && (state_ff == S_IDLE);
   assign d_empty = (dptr_ff == '0);
   assign d_full  = (dptr_ff >= DPW'(STACK_DEPTH));
   assign j_empty = (jptr_ff == '0);
   assign j_full  = (jptr_ff >= JPW'(JOURNAL_DEPTH));

   always_comb begin
      state_in      = state_ff;
      dptr_in       = dptr_ff;
      jptr_in       = jptr_ff;
      req_in        = req_ff;
      status_in     = status_ff;
      fwd_in        = fwd_ff;
      fwd_val_in    = fwd_val_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = rsp_data_ff;
      d_we          = 1'b0;
      j_we          = 1'b0;
      d_wdata       = req_ff.value;
      j_wdata       = '{kind: swuj_pkg::KIND_PUSH, value: req_ff.value};

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               req_in   = req_data;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            status_in = swuj_pkg::ST_OK;
            case (req_ff.op)
               swuj_pkg::OP_PUSH: begin
                  if (d_full || j_full) begin
                     status_in = swuj_pkg::ST_FULL;
                  end else begin
                     d_we    = 1'b1;
                     j_we    = 1'b1;
                     dptr_in = dptr_ff + DPW'(1);
                     jptr_in = jptr_ff + JPW'(1);
                  end
               end
               swuj_pkg::OP_POP: begin
                  if (d_empty) begin
                     status_in = swuj_pkg::ST_EMPTY;
                  end else if (j_full) begin
                     status_in = swuj_pkg::ST_FULL;
                  end else begin
                     j_we    = 1'b1;
                     j_wdata = '{kind: swuj_pkg::KIND_POP, value: d_rdata};
                     dptr_in = dptr_ff - DPW'(1);
                     jptr_in = jptr_ff + JPW'(1);
                  end
               end
               swuj_pkg::OP_UNDO: begin
                  if (j_empty) begin
                     status_in = swuj_pkg::ST_NOUNDO;
                  end else if (j_rdata.kind == swuj_pkg::KIND_PUSH) begin
                     if (d_empty) begin
                        status_in = swuj_pkg::ST_FULL;
                     end else begin
                        dptr_in = dptr_ff - DPW'(1);
                        jptr_in = jptr_ff - JPW'(1);
                     end
                  end else begin
                     if (d_full) begin
                        status_in = swuj_pkg::ST_FULL;
                     end else begin
                        // restore the popped value
                        d_we    = 1'b1;
                        d_wdata = j_rdata.value;
                        dptr_in = dptr_ff + DPW'(1);
                        jptr_in = jptr_ff - JPW'(1);
                     end
                  end
               end
               default: begin
               end
            endcase
            // the new top is the written entry when something was written
            fwd_in     = d_we;
            fwd_val_in = d_wdata;
            state_in   = S_TOP;
         end
         S_TOP: begin
            rsp_strobe_in         = 1'b1;
            rsp_data_in.depth     = swuj_pkg::DEPTH_W'(dptr_ff);
            rsp_data_in.status    = status_ff;
            if (d_empty) begin
               rsp_data_in.top_value = '0;
            end else if (fwd_ff) begin
               rsp_data_in.top_value = fwd_val_ff;
            end else begin
               rsp_data_in.top_value = d_rdata;
            end
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // read the current top while idle, the new top during execute
   assign d_rd_ptr = ((state_ff == S_EXEC) ? dptr_in : dptr_ff) - DPW'(1);
   assign j_rd_ptr = jptr_ff - JPW'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         dptr_ff       <= '0;
         jptr_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         dptr_ff       <= dptr_in;
         jptr_ff       <= jptr_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      req_ff      <= req_in;
      status_ff   <= status_in;
      fwd_ff      <= fwd_in;
      fwd_val_ff  <= fwd_val_in;
      rsp_data_ff <= rsp_data_in;
   end

   swuj_ram #(
      .WIDTH(swuj_pkg::VALUE_W),
      .DEPTH(STACK_DEPTH)
   ) u_data_ram (
      .clock  (clock),
      .wr_en  (d_we),
      .wr_addr(dptr_ff[DAW-1:0]),
      .wr_data(d_wdata),
      .rd_addr(d_rd_ptr[DAW-1:0]),
      .rd_data(d_rdata)
   );

   swuj_ram #(
      .WIDTH(swuj_pkg::RECORD_W),
      .DEPTH(JOURNAL_DEPTH)
   ) u_journal_ram (
      .clock  (clock),
      .wr_en  (j_we),
      .wr_addr(jptr_ff[JAW-1:0]),
      .wr_data(j_wdata),
      .rd_addr(j_rd_ptr[JAW-1:0]),
      .rd_data(j_rdata)
   );

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   `ASSERT_NEXT(a_rsp_after_accept, clock, reset, accept, ##2 rsp_strobe)
   `ASSERT_IMPLIES(a_dptr_bound, clock, reset, 1'b1, dptr_ff <= DPW'(STACK_DEPTH))
   `ASSERT_IMPLIES(a_jptr_bound, clock, reset, 1'b1, jptr_ff <= JPW'(JOURNAL_DEPTH))
   `ASSERT_IMPLIES(a_ok_moves_ptrs, clock, reset,
      state_ff == S_EXEC && status_in == swuj_pkg::ST_OK && req_ff.op != swuj_pkg::OP_SPARE,
      jptr_in != jptr_ff)

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the stack with undo journal
// ----------------------------------------------------------------------------
// A short table of requests walks through empty, extreme and undo cases; the
// expected result is written out for the reset, extreme and error rows, the
// other rows go to the model. Random bursts of pushes, pops, undos and
// alternating push/pop pairs follow; they drive the data stack and the
// journal into their full states. Every other result is compared with a
// behavioral model kept inside the bench.
// ----------------------------------------------------------------------------
module testbench;

   localparam int RANDOM_REQUESTS = 430;
   localparam int CYCLE_LIMIT = 100000;

   typedef enum int {
      BURST_MIXED, BURST_FILL, BURST_POPS, BURST_DRAIN, BURST_SEESAW
   } burst_kind_type;

   typedef struct {
      swuj_pkg::req_type req;
      swuj_pkg::rsp_type rsp;
      bit                fixed;
   } directed_row_type;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   swuj_pkg::req_type req_data;
   logic              rsp_strobe;
   swuj_pkg::rsp_type rsp_data;

   // model state
   logic signed [swuj_pkg::VALUE_W-1:0] stack_mem [swuj_pkg::STACK_DEPTH_DEF];
   swuj_pkg::record_type journal_mem [swuj_pkg::JOURNAL_DEPTH_DEF];
   int stack_cnt;
   int journal_cnt;

   swuj_pkg::rsp_type owed_results [$];
   directed_row_type  directed_rows [$];
   swuj_pkg::rsp_type expected_rsp;
   swuj_pkg::rsp_type accepted_rsp;
   bit                row_fixed;
   swuj_pkg::rsp_type row_rsp;
   int                idle_pct;
   int                errors;
   int                cycles;

   stack_with_undo_journal DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic swuj_pkg::rsp_type apply_stack_op(input swuj_pkg::req_type r);
      swuj_pkg::rsp_type    res;
      swuj_pkg::record_type rec;
      res.status = swuj_pkg::ST_OK;
      case (r.op)
         swuj_pkg::OP_PUSH: begin
            if (stack_cnt >= swuj_pkg::STACK_DEPTH_DEF ||
                journal_cnt >= swuj_pkg::JOURNAL_DEPTH_DEF) begin
               res.status = swuj_pkg::ST_FULL;
            end else begin
               stack_mem[stack_cnt] = r.value;
               stack_cnt++;
               rec.kind = swuj_pkg::KIND_PUSH;
               rec.value = r.value;
               journal_mem[journal_cnt] = rec;
               journal_cnt++;
            end
         end
         swuj_pkg::OP_POP: begin
            if (stack_cnt == 0) begin
               res.status = swuj_pkg::ST_EMPTY;
            end else if (journal_cnt >= swuj_pkg::JOURNAL_DEPTH_DEF) begin
               res.status = swuj_pkg::ST_FULL;
            end else begin
               rec.kind = swuj_pkg::KIND_POP;
               rec.value = stack_mem[stack_cnt-1];
               stack_cnt--;
               journal_mem[journal_cnt] = rec;
               journal_cnt++;
            end
         end
         swuj_pkg::OP_UNDO: begin
            if (journal_cnt == 0) begin
               res.status = swuj_pkg::ST_NOUNDO;
            end else begin
               rec = journal_mem[journal_cnt-1];
               if (rec.kind == swuj_pkg::KIND_PUSH) begin
                  if (stack_cnt == 0) begin
                     res.status = swuj_pkg::ST_FULL;
                  end else begin
                     stack_cnt--;
                     journal_cnt--;
                  end
               end else if (stack_cnt >= swuj_pkg::STACK_DEPTH_DEF) begin
                  res.status = swuj_pkg::ST_FULL;
               end else begin
                  stack_mem[stack_cnt] = rec.value;
                  stack_cnt++;
                  journal_cnt--;
               end
            end
         end
         default: begin
         end
      endcase
      res.depth = swuj_pkg::DEPTH_W'(stack_cnt);
      res.top_value = (stack_cnt > 0) ? stack_mem[stack_cnt-1] : '0;
      return res;
   endfunction

   function automatic swuj_pkg::req_type make_request(input burst_kind_type kind,
                                                      input int idx);
      swuj_pkg::req_type r;
      int                pick;
      pick = $urandom_range(99);
      r.value = $urandom;
      // extremes now and then
      if ($urandom_range(7) == 0) begin
         case ($urandom_range(3))
            0: r.value = 32'sh7fffffff;
            1: r.value = 32'sh80000000;
            2: r.value = '0;
            default: r.value = -32'sd1;
         endcase
      end
      case (kind)
         BURST_FILL:   r.op = (pick < 92) ? swuj_pkg::OP_PUSH : swuj_pkg::OP_UNDO;
         BURST_POPS:   r.op = (pick < 90) ? swuj_pkg::OP_POP : swuj_pkg::OP_PUSH;
         BURST_DRAIN:  r.op = (pick < 95) ? swuj_pkg::OP_UNDO : swuj_pkg::OP_POP;
         BURST_SEESAW: r.op = (idx % 2 == 0) ? swuj_pkg::OP_PUSH : swuj_pkg::OP_POP;
         default: begin
            if (pick < 40) r.op = swuj_pkg::OP_PUSH;
            else if (pick < 70) r.op = swuj_pkg::OP_POP;
            else if (pick < 94) r.op = swuj_pkg::OP_UNDO;
            else r.op = swuj_pkg::OP_SPARE;
         end
      endcase
      return r;
   endfunction

   // row with its result written out
   task automatic add_row(input logic [swuj_pkg::OP_W-1:0] op,
                          input logic signed [swuj_pkg::VALUE_W-1:0] value,
                          input logic signed [swuj_pkg::VALUE_W-1:0] top, input int depth,
                          input logic [swuj_pkg::STATUS_W-1:0] status);
      directed_row_type row;
      row.req.op = op;
      row.req.value = value;
      row.rsp.top_value = top;
      row.rsp.depth = swuj_pkg::DEPTH_W'(depth);
      row.rsp.status = status;
      row.fixed = 1'b1;
      directed_rows.push_back(row);
   endtask

   // row checked against the model
   task automatic add_free_row(input logic [swuj_pkg::OP_W-1:0] op,
                               input logic signed [swuj_pkg::VALUE_W-1:0] value);
      directed_row_type row;
      row.req.op = op;
      row.req.value = value;
      row.rsp = '0;
      row.fixed = 1'b0;
      directed_rows.push_back(row);
   endtask

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_request(input swuj_pkg::req_type r, input bit fixed,
                               input swuj_pkg::rsp_type fixed_rsp);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      row_fixed = fixed;
      row_rsp = fixed_rsp;
      start <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
   endtask

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d results outstanding", $time, owed_results.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   // results first, so an extra strobe is not hidden by a request taken at the same edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) begin
            if (owed_results.size() == 0) begin
               errors++;
               $display("%0t: unexpected result top=%0d depth=%0d status=%0d", $time,
                        rsp_data.top_value, rsp_data.depth, rsp_data.status);
            end else begin
               expected_rsp = owed_results.pop_front();
               if (rsp_data !== expected_rsp) begin
                  errors++;
                  $display("%0t: mismatch expected top=%0d depth=%0d status=%0d,",
                           $time, expected_rsp.top_value, expected_rsp.depth,
                           expected_rsp.status);
                  $display("%0t:          got top=%0d depth=%0d status=%0d",
                           $time, rsp_data.top_value, rsp_data.depth, rsp_data.status);
               end
            end
         end
         if (start && !busy) begin
            accepted_rsp = apply_stack_op(req_data);
            if (row_fixed) accepted_rsp = row_rsp;
            owed_results.push_back(accepted_rsp);
         end
      end
   end

   initial begin
      int                sent;
      int                phase;
      int                len;
      int                idle_plan [3];
      burst_kind_type    kind;
      swuj_pkg::req_type r;

      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      row_fixed = 1'b0;
      row_rsp = '0;
      idle_pct = 0;
      errors = 0;
      cycles = 0;
      stack_cnt = 0;
      journal_cnt = 0;
      idle_plan = '{0, 51, 6};

      // fresh stack, extremes, spare op, then undo of both record kinds
      add_row(swuj_pkg::OP_POP,   32'sd0,        32'sd0,        0, swuj_pkg::ST_EMPTY);
      add_row(swuj_pkg::OP_UNDO,  32'sd0,        32'sd0,        0, swuj_pkg::ST_NOUNDO);
      add_row(swuj_pkg::OP_SPARE, 32'sh7fffffff, 32'sd0,        0, swuj_pkg::ST_OK);
      add_row(swuj_pkg::OP_PUSH,  32'sh7fffffff, 32'sh7fffffff, 1, swuj_pkg::ST_OK);
      add_row(swuj_pkg::OP_PUSH,  32'sh80000000, 32'sh80000000, 2, swuj_pkg::ST_OK);
      add_row(swuj_pkg::OP_PUSH,  32'sd0,        32'sd0,        3, swuj_pkg::ST_OK);
      add_row(swuj_pkg::OP_PUSH,  -32'sd1,       -32'sd1,       4, swuj_pkg::ST_OK);
      add_free_row(swuj_pkg::OP_SPARE, 32'sd123);
      add_free_row(swuj_pkg::OP_POP,   32'sd55);
      add_free_row(swuj_pkg::OP_POP,   32'sd0);
      add_free_row(swuj_pkg::OP_UNDO,  32'sd0);
      add_free_row(swuj_pkg::OP_UNDO,  32'sd0);
      add_free_row(swuj_pkg::OP_UNDO,  32'sd0);
      add_free_row(swuj_pkg::OP_POP,   32'sd0);
      add_free_row(swuj_pkg::OP_POP,   32'sd0);
      add_free_row(swuj_pkg::OP_POP,   32'sd0);
      add_row(swuj_pkg::OP_POP,   32'sd0,        32'sd0,        0, swuj_pkg::ST_EMPTY);
      add_free_row(swuj_pkg::OP_UNDO,  32'sd0);
      add_free_row(swuj_pkg::OP_UNDO,  32'sd0);
      add_free_row(swuj_pkg::OP_UNDO,  32'sd0);
      add_free_row(swuj_pkg::OP_UNDO,  32'sd0);
      add_free_row(swuj_pkg::OP_UNDO,  32'sd0);
      add_free_row(swuj_pkg::OP_UNDO,  32'sd0);
      add_row(swuj_pkg::OP_UNDO,  32'sd0,        32'sd0,        0, swuj_pkg::ST_NOUNDO);

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i]) begin
         send_request(directed_rows[i].req, directed_rows[i].fixed, directed_rows[i].rsp);
      end

      sent = 0;
      phase = 0;
      while (sent < RANDOM_REQUESTS) begin
         kind = burst_kind_type'($urandom_range(4));
         case (kind)
            BURST_FILL:   len = $urandom_range(60, 72);
            BURST_POPS:   len = $urandom_range(20, 50);
            BURST_DRAIN:  len = $urandom_range(40, 140);
            BURST_SEESAW: len = $urandom_range(20, 60);
            default:      len = $urandom_range(10, 30);
         endcase
         idle_pct = idle_plan[phase % 3];
         phase++;
         for (int i = 0; i < len && sent < RANDOM_REQUESTS; i++) begin
            r = make_request(kind, i);
            send_request(r, 1'b0, '0);
            sent++;
         end
      end
      start <= 1'b0;

      while (owed_results.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
      if (errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/swuj_pkg.sv
rtl/swuj_ram.sv
rtl/stack_with_undo_journal.sv
bench/testbench.sv
